[sv/pgpfr_pkg.sv]
// ----------------------------------------------------------------------------
// pgpfr_pkg
// Shared types and codes for the OpenPGP packet framer.
// ----------------------------------------------------------------------------
package pgpfr_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int BODY_LEN_W      = 32;
  localparam int TYPE_W          = 6;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BODY   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_BAD_TAG     = 2'd0,
    ERR_PARTIAL_LEN = 2'd1,
    ERR_TRUNC_HDR   = 2'd2,
    ERR_TRUNC_BODY  = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_NEWFIRST = 3'd1,
    PH_LENMORE  = 3'd2,
    PH_BODY     = 3'd3,
    PH_OPEN     = 3'd4,
    PH_DRAIN    = 3'd5
  } phase_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [TYPE_W-1:0]     packet_type;
    logic [BODY_LEN_W-1:0] body_length;
    logic                  length_open;
    logic [7:0]            body_byte;
    logic                  last_in_packet;
    logic [1:0]            error_code;
  } result_t;

endpackage

[sv/pgpfr_ifs.sv]
// ----------------------------------------------------------------------------
// pgpfr channel interfaces
// Byte input channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pgpfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface pgpfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [5:0]  packet_type;
  logic [31:0] body_length;
  logic        length_open;
  logic [7:0]  body_byte;
  logic        last_in_packet;
  logic [1:0]  error_code;

  modport source (output valid, output kind, output packet_type, output body_length,
                  output length_open, output body_byte, output last_in_packet,
                  output error_code, input ready);
  modport sink   (input valid, input kind, input packet_type, input body_length,
                  input length_open, input body_byte, input last_in_packet,
                  input error_code, output ready);
endinterface

[sv/openpgp_packet_framer.sv]
// ----------------------------------------------------------------------------
// openpgp_packet_framer
// Splits an encoded OpenPGP byte stream into header, body and error results.
// ----------------------------------------------------------------------------
// One byte is taken per clock while in_if.ready is high. Each byte updates the
// header/length state and produces at most one result, which is held in a single
// output register and shown the cycle after the byte is taken. in_if.ready stays
// high while that register is empty or being read in the same cycle, so a steady
// stream runs at one byte per cycle and the only limit is the downstream ready.
// Lengths above 2^LENGTH_BITS-1 saturate. After an error, bytes are dropped up to
// and including the one marked end_of_input; end_of_input always resets framing.
module openpgp_packet_framer import pgpfr_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  pgpfr_in_if.sink     in_if,
  pgpfr_out_if.source  out_if
);

  localparam logic [32:0]            LEN_MAX_EXT = (33'd1 << LENGTH_BITS) - 33'd1;
  localparam logic [LENGTH_BITS-1:0] REM_ONE     = {{(LENGTH_BITS-1){1'b0}}, 1'b1};

  phase_t                  phase_r, phase_nxt;
  logic [TYPE_W-1:0]       held_type_r, held_type_nxt;
  logic [2:0]              lbl_r, lbl_nxt;
  logic [31:0]             acc_r, acc_nxt;
  logic [LENGTH_BITS-1:0]  rem_r, rem_nxt;
  logic                    two_r, two_nxt;
  logic                    out_valid_r;
  result_t                 out_r;

  logic                    res_valid;
  result_t                 res;

  logic                    take;
  logic [7:0]              b;
  logic                    eoi;
  logic [31:0]             acc_shift;
  logic [2:0]              lbl_dec;
  logic                    len_done;
  logic [32:0]             len_raw;
  logic [LENGTH_BITS-1:0]  len_sat;
  logic                    len_zero;
  logic [LENGTH_BITS-1:0]  rem_dec;
  logic                    first_short;
  logic                    first_two;
  logic                    first_five;

  assign take       = in_if.valid && in_if.ready;
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign b          = in_if.data_byte;
  assign eoi        = in_if.end_of_input;

  assign acc_shift  = {acc_r[23:0], b};
  assign lbl_dec    = lbl_r - 3'd1;
  assign len_done   = (lbl_dec == 3'd0);
  assign first_short = (b < 8'd192);
  assign first_two   = (b >= 8'd192) && (b < 8'd224);
  assign first_five  = (b == 8'd255);

  // header length from either the single new-format byte or the gathered bytes
  always_comb begin
    if (phase_r == PH_NEWFIRST) begin
      len_raw = {25'd0, b};
    end else begin
      len_raw = {1'b0, acc_shift} + (two_r ? 33'd192 : 33'd0);
    end
  end

  assign len_sat  = (len_raw > LEN_MAX_EXT) ? LEN_MAX_EXT[LENGTH_BITS-1:0]
                                            : len_raw[LENGTH_BITS-1:0];
  assign len_zero = (len_raw == 33'd0);
  assign rem_dec  = (rem_r != '0) ? rem_r - REM_ONE : '0;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: begin
        if (eoi)                  phase_nxt = PH_IDLE;
        else if (!b[7])           phase_nxt = PH_DRAIN;
        else if (b[6])            phase_nxt = PH_NEWFIRST;
        else if (b[1:0] == 2'd3)  phase_nxt = PH_OPEN;
        else                      phase_nxt = PH_LENMORE;
      end
      PH_NEWFIRST: begin
        if (eoi)                          phase_nxt = PH_IDLE;
        else if (first_short)             phase_nxt = len_zero ? PH_IDLE : PH_BODY;
        else if (first_two || first_five) phase_nxt = PH_LENMORE;
        else                              phase_nxt = PH_DRAIN;
      end
      PH_LENMORE: begin
        if (eoi)           phase_nxt = PH_IDLE;
        else if (len_done) phase_nxt = len_zero ? PH_IDLE : PH_BODY;
        else               phase_nxt = PH_LENMORE;
      end
      PH_BODY: begin
        phase_nxt = (eoi || rem_dec == '0) ? PH_IDLE : PH_BODY;
      end
      PH_OPEN:  phase_nxt = eoi ? PH_IDLE : PH_OPEN;
      PH_DRAIN: phase_nxt = eoi ? PH_IDLE : PH_DRAIN;
      default:  phase_nxt = PH_IDLE;
    endcase
  end

  // result and datapath updates
  always_comb begin
    held_type_nxt = held_type_r;
    lbl_nxt       = lbl_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    two_nxt       = two_r;
    res_valid     = 1'b0;
    res           = '0;

    case (phase_r)
      PH_IDLE: begin
        if (!b[7]) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_BAD_TAG;
        end else begin
          two_nxt = 1'b0;
          acc_nxt = '0;
          if (b[6]) begin
            held_type_nxt = b[5:0];
            if (eoi) begin
              res_valid       = 1'b1;
              res.kind        = KIND_ERROR;
              res.packet_type = b[5:0];
              res.error_code  = ERR_TRUNC_HDR;
            end
          end else begin
            held_type_nxt = {2'b00, b[5:2]};
            case (b[1:0])
              2'd0:    lbl_nxt = 3'd1;
              2'd1:    lbl_nxt = 3'd2;
              2'd2:    lbl_nxt = 3'd4;
              default: lbl_nxt = lbl_r;
            endcase
            if (b[1:0] == 2'd3) begin
              res_valid          = 1'b1;
              res.kind           = KIND_HEADER;
              res.packet_type    = {2'b00, b[5:2]};
              res.length_open    = 1'b1;
              res.last_in_packet = eoi;
            end else if (eoi) begin
              res_valid       = 1'b1;
              res.kind        = KIND_ERROR;
              res.packet_type = {2'b00, b[5:2]};
              res.error_code  = ERR_TRUNC_HDR;
            end
          end
        end
      end

      PH_NEWFIRST, PH_LENMORE: begin
        if (phase_r == PH_LENMORE) begin
          acc_nxt = acc_shift;
          lbl_nxt = lbl_dec;
          if (len_done) two_nxt = 1'b0;
        end else if (first_two) begin
          acc_nxt = {27'd0, b[4:0]};
          lbl_nxt = 3'd1;
          two_nxt = 1'b1;
        end else if (first_five) begin
          acc_nxt = '0;
          lbl_nxt = 3'd4;
          two_nxt = 1'b0;
        end

        res.packet_type = held_type_r;
        if ((phase_r == PH_NEWFIRST && first_short) ||
            (phase_r == PH_LENMORE && len_done)) begin
          // header complete
          rem_nxt   = len_sat;
          res_valid = 1'b1;
          if (eoi && !len_zero) begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TRUNC_BODY;
          end else begin
            res.kind           = KIND_HEADER;
            res.body_length    = BODY_LEN_W'(len_sat);
            res.last_in_packet = len_zero;
          end
        end else if (phase_r == PH_NEWFIRST && !first_two && !first_five) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_PARTIAL_LEN;
        end else if (eoi) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_TRUNC_HDR;
        end
      end

      PH_BODY: begin
        res_valid       = 1'b1;
        res.packet_type = held_type_r;
        if (eoi && rem_r > REM_ONE) begin
          res.kind       = KIND_ERROR;
          res.error_code = ERR_TRUNC_BODY;
        end else begin
          rem_nxt            = rem_dec;
          res.kind           = KIND_BODY;
          res.body_byte      = b;
          res.last_in_packet = (rem_dec == '0);
        end
      end

      PH_OPEN: begin
        res_valid          = 1'b1;
        res.kind           = KIND_BODY;
        res.packet_type    = held_type_r;
        res.body_byte      = b;
        res.last_in_packet = eoi;
      end

      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      held_type_r <= '0;
      lbl_r       <= '0;
      acc_r       <= '0;
      rem_r       <= '0;
      two_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r     <= phase_nxt;
        held_type_r <= held_type_nxt;
        lbl_r       <= lbl_nxt;
        acc_r       <= acc_nxt;
        rem_r       <= rem_nxt;
        two_r       <= two_nxt;
        out_valid_r <= res_valid;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded only when a transfer makes a result
  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.kind           = out_r.kind;
  assign out_if.packet_type    = out_r.packet_type;
  assign out_if.body_length    = out_r.body_length;
  assign out_if.length_open    = out_r.length_open;
  assign out_if.body_byte      = out_r.body_byte;
  assign out_if.last_in_packet = out_r.last_in_packet;
  assign out_if.error_code     = out_r.error_code;

endmodule

[sv/pgpfr_checker.sv]
// ----------------------------------------------------------------------------
// pgpfr_checker
// Port-level checks on the packet framer, bound to openpgp_packet_framer.
// ----------------------------------------------------------------------------
module pgpfr_checker import pgpfr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [31:0] out_body_length,
  input logic        out_length_open,
  input logic        out_last,
  input logic [7:0]  out_body_byte
);

  // a stalled result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_body_length) && $stable(out_body_byte) && $stable(out_last))
    else $error("result changed while stalled");

  // input side never blocks while the result register is free
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready with empty output register");

  // an empty fixed-length header closes its packet
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_HEADER && !out_length_open && out_body_length == 32'd0
      |-> out_last)
    else $error("zero-length header without last mark");

  // open-length headers and errors carry no length, errors carry no last mark
  a_field_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_ERROR ||
                  (out_kind == KIND_HEADER && out_length_open))
      |-> out_body_length == 32'd0 && (out_kind != KIND_ERROR || !out_last))
    else $error("unused result field not zero");

endmodule

bind openpgp_packet_framer pgpfr_checker u_pgpfr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_kind        (out_if.kind),
  .out_body_length (out_if.body_length),
  .out_length_open (out_if.length_open),
  .out_last        (out_if.last_in_packet),
  .out_body_byte   (out_if.body_byte)
);

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for openpgp_packet_framer. A directed table walks the
// header formats, length encodings and error paths. Random segments of
// well-formed, truncated and garbage packet streams follow. Every byte
// transfer is run through a local framing model, and each result transfer is
// compared field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import pgpfr_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_BYTES    = 500;
  localparam int MAX_REPORTS     = 10;

  // old-format length-of-length codes
  localparam logic [1:0] OLD_LEN_1    = 2'd0;
  localparam logic [1:0] OLD_LEN_2    = 2'd1;
  localparam logic [1:0] OLD_LEN_4    = 2'd2;
  localparam logic [1:0] OLD_LEN_OPEN = 2'd3;

  // new-format first length byte ranges
  localparam logic [7:0] NEW_LEN_TWO_MIN     = 8'd192;
  localparam logic [7:0] NEW_LEN_PARTIAL_MIN = 8'd224;
  localparam logic [7:0] NEW_LEN_FIVE        = 8'd255;

  typedef enum int {
    FMT_NEW1, FMT_NEW2, FMT_NEW5, FMT_OLD1, FMT_OLD2, FMT_OLD4, FMT_OPEN
  } hdr_fmt_t;

  typedef struct {
    logic [7:0] data;
    bit         eoi;
    bit         typed;
    bit         has_result;
    result_t    res;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
  } stream_byte_t;

  logic clk;
  logic rst_n;

  pgpfr_in_if  in_ch ();
  pgpfr_out_if out_ch ();

  openpgp_packet_framer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // framing model state
  phase_t      frame_phase = PH_IDLE;
  logic [5:0]  frame_type  = '0;
  logic [2:0]  frame_len_left = '0;
  logic [31:0] frame_acc   = '0;
  logic [31:0] frame_body_left = '0;
  bit          frame_two_byte = 0;

  stim_row_t    offered_bytes[$];
  result_t      pending_results[$];
  stream_byte_t segment[$];

  int  bad_results = 0;
  int  live_bytes  = 0;
  int  bytes_in    = 0;
  int  n_headers   = 0;
  int  n_bodies    = 0;
  int  n_errors    = 0;
  int  cycles      = 0;
  int  no_gap_left = 0;
  bit  hold_req    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic result_t blank(kind_t k, logic [5:0] t);
    result_t r;
    r = '0;
    r.kind = k;
    r.packet_type = t;
    return r;
  endfunction

  function automatic result_t frame_error(logic [5:0] t, err_t code, bit eoi);
    result_t r;
    r = blank(KIND_ERROR, t);
    r.error_code = code;
    frame_phase = eoi ? PH_IDLE : PH_DRAIN;
    return r;
  endfunction

  function automatic result_t close_header(logic [63:0] len_in, bit eoi);
    logic [63:0] cap;
    logic [63:0] len;
    result_t     r;
    cap = (64'd1 << LENGTH_BITS_DEF) - 64'd1;
    len = (len_in > cap) ? cap : len_in;
    if (eoi && len != 0)
      return frame_error(frame_type, ERR_TRUNC_BODY, 1'b1);
    r = blank(KIND_HEADER, frame_type);
    r.body_length = len[31:0];
    r.last_in_packet = (len == 0);
    frame_body_left = len[31:0];
    frame_phase = (len == 0 || eoi) ? PH_IDLE : PH_BODY;
    return r;
  endfunction

  function automatic bit frame_byte(input logic [7:0] b, input bit eoi, output result_t r);
    logic [63:0] acc;
    r = '0;
    case (frame_phase)
      PH_IDLE: begin
        if (!b[7]) begin
          r = frame_error(6'd0, ERR_BAD_TAG, eoi);
          return 1'b1;
        end
        frame_two_byte = 1'b0;
        frame_acc = '0;
        if (b[6]) begin
          frame_type = b[5:0];
          if (eoi) begin
            r = frame_error(frame_type, ERR_TRUNC_HDR, 1'b1);
            return 1'b1;
          end
          frame_phase = PH_NEWFIRST;
          return 1'b0;
        end
        frame_type = {2'b00, b[5:2]};
        case (b[1:0])
          OLD_LEN_1: frame_len_left = 3'd1;
          OLD_LEN_2: frame_len_left = 3'd2;
          OLD_LEN_4: frame_len_left = 3'd4;
          default: begin
            // indeterminate length, body runs to end of input
            r = blank(KIND_HEADER, frame_type);
            r.length_open = 1'b1;
            r.last_in_packet = eoi;
            frame_phase = eoi ? PH_IDLE : PH_OPEN;
            return 1'b1;
          end
        endcase
        if (eoi) begin
          r = frame_error(frame_type, ERR_TRUNC_HDR, 1'b1);
          return 1'b1;
        end
        frame_phase = PH_LENMORE;
        return 1'b0;
      end
      PH_NEWFIRST: begin
        if (b < NEW_LEN_TWO_MIN) begin
          r = close_header({56'd0, b}, eoi);
          return 1'b1;
        end
        if (b < NEW_LEN_PARTIAL_MIN) begin
          frame_acc = {24'd0, b - NEW_LEN_TWO_MIN};
          frame_len_left = 3'd1;
          frame_two_byte = 1'b1;
        end else if (b == NEW_LEN_FIVE) begin
          frame_acc = '0;
          frame_len_left = 3'd4;
          frame_two_byte = 1'b0;
        end else begin
          r = frame_error(frame_type, ERR_PARTIAL_LEN, eoi);
          return 1'b1;
        end
        if (eoi) begin
          r = frame_error(frame_type, ERR_TRUNC_HDR, 1'b1);
          return 1'b1;
        end
        frame_phase = PH_LENMORE;
        return 1'b0;
      end
      PH_LENMORE: begin
        acc = {32'd0, frame_acc[23:0], b};
        frame_acc = acc[31:0];
        frame_len_left = frame_len_left - 3'd1;
        if (frame_len_left == 0) begin
          if (frame_two_byte)
            acc = acc + {56'd0, NEW_LEN_TWO_MIN};
          frame_two_byte = 1'b0;
          r = close_header(acc, eoi);
          return 1'b1;
        end
        if (eoi) begin
          r = frame_error(frame_type, ERR_TRUNC_HDR, 1'b1);
          return 1'b1;
        end
        return 1'b0;
      end
      PH_BODY: begin
        if (eoi && frame_body_left > 1) begin
          r = frame_error(frame_type, ERR_TRUNC_BODY, 1'b1);
          return 1'b1;
        end
        if (frame_body_left != 0)
          frame_body_left = frame_body_left - 1;
        r = blank(KIND_BODY, frame_type);
        r.body_byte = b;
        r.last_in_packet = (frame_body_left == 0);
        frame_phase = (frame_body_left == 0 || eoi) ? PH_IDLE : PH_BODY;
        return 1'b1;
      end
      PH_OPEN: begin
        r = blank(KIND_BODY, frame_type);
        r.body_byte = b;
        r.last_in_packet = eoi;
        if (eoi)
          frame_phase = PH_IDLE;
        return 1'b1;
      end
      default: begin
        // draining after an error
        if (eoi)
          frame_phase = PH_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- table rows

  function automatic stim_row_t row_pred(logic [7:0] d, bit e);
    stim_row_t s;
    s.data = d;
    s.eoi = e;
    s.typed = 1'b0;
    s.has_result = 1'b0;
    s.res = '0;
    return s;
  endfunction

  function automatic stim_row_t row_none(logic [7:0] d, bit e);
    stim_row_t s;
    s = row_pred(d, e);
    s.typed = 1'b1;
    return s;
  endfunction

  function automatic stim_row_t row_err(logic [7:0] d, bit e, logic [5:0] t, err_t code);
    stim_row_t s;
    s = row_none(d, e);
    s.has_result = 1'b1;
    s.res = blank(KIND_ERROR, t);
    s.res.error_code = code;
    return s;
  endfunction

  function automatic stim_row_t row_hdr(logic [7:0] d, bit e, logic [5:0] t,
                                        logic [31:0] len, bit open, bit last);
    stim_row_t s;
    s = row_none(d, e);
    s.has_result = 1'b1;
    s.res = blank(KIND_HEADER, t);
    s.res.body_length = len;
    s.res.length_open = open;
    s.res.last_in_packet = last;
    return s;
  endfunction

  function automatic string describe(result_t r);
    return $sformatf("kind=%0d type=%0d len=%0d open=%0b byte=%02h last=%0b err=%0d",
                     r.kind, r.packet_type, r.body_length, r.length_open,
                     r.body_byte, r.last_in_packet, r.error_code);
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int pick_gap();
    int r;
    if (no_gap_left > 0) begin
      no_gap_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3)
      no_gap_left = $urandom_range(30, 80);
    if (r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  task automatic send_byte(input logic [7:0] d, input bit e, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.end_of_input <= e;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic add_byte(logic [7:0] d);
    segment.push_back({d, 1'b0});
  endtask

  // one input buffer: well-formed packets, a cut-off stream, or garbage
  task automatic build_segment();
    int          mode;
    int          npk;
    int          nbody;
    int          cut;
    hdr_fmt_t    fmt;
    logic [31:0] len;
    logic [31:0] v;
    logic [5:0]  ptype;
    bit          big;
    segment.delete();
    mode = $urandom_range(99);
    if (mode >= 85) begin
      if ($urandom_range(2) == 0) begin
        // new-format tag with a partial body length
        add_byte({2'b11, 6'($urandom_range(63))});
        add_byte(8'($urandom_range(224, 254)));
      end
      nbody = $urandom_range(1, 8);
      repeat (nbody) add_byte(8'($urandom_range(255)));
    end else begin
      npk = $urandom_range(1, 3);
      for (int p = 0; p < npk; p++) begin
        fmt = hdr_fmt_t'($urandom_range(6));
        if (fmt == FMT_OPEN && p != npk - 1)
          fmt = FMT_NEW1;
        // two-byte lengths mean 192+ body bytes, keep them rare when complete
        if (fmt == FMT_NEW2 && mode < 70 && $urandom_range(14) != 0)
          fmt = FMT_NEW1;
        big = (mode >= 70) && ($urandom_range(2) == 0);
        len = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom_range(1, 6));
        ptype = 6'($urandom_range(63));
        case (fmt)
          FMT_NEW1: begin
            if (big) len = $urandom_range(191);
            add_byte({2'b11, ptype});
            add_byte(len[7:0]);
          end
          FMT_NEW2: begin
            v = big ? 32'($urandom_range(8191)) : 32'($urandom_range(3));
            len = v + 32'd192;
            add_byte({2'b11, ptype});
            add_byte(NEW_LEN_TWO_MIN + {3'b000, v[12:8]});
            add_byte(v[7:0]);
          end
          FMT_NEW5: begin
            if (big) len = $urandom;
            add_byte({2'b11, ptype});
            add_byte(NEW_LEN_FIVE);
            add_byte(len[31:24]);
            add_byte(len[23:16]);
            add_byte(len[15:8]);
            add_byte(len[7:0]);
          end
          FMT_OLD1: begin
            if (big) len = $urandom_range(255);
            add_byte({2'b10, ptype[3:0], OLD_LEN_1});
            add_byte(len[7:0]);
          end
          FMT_OLD2: begin
            if (big) len = $urandom_range(65535);
            add_byte({2'b10, ptype[3:0], OLD_LEN_2});
            add_byte(len[15:8]);
            add_byte(len[7:0]);
          end
          FMT_OLD4: begin
            if (big) len = $urandom;
            add_byte({2'b10, ptype[3:0], OLD_LEN_4});
            add_byte(len[31:24]);
            add_byte(len[23:16]);
            add_byte(len[15:8]);
            add_byte(len[7:0]);
          end
          default: begin
            add_byte({2'b10, ptype[3:0], OLD_LEN_OPEN});
            len = $urandom_range(5);
          end
        endcase
        nbody = (big && len > 8) ? 8 : int'(len);
        repeat (nbody) add_byte(8'($urandom_range(255)));
      end
      if (mode >= 70) begin
        cut = $urandom_range(segment.size() - 1);
        while (segment.size() > cut + 1)
          void'(segment.pop_back());
      end
    end
    segment[segment.size() - 1].eoi = 1'b1;
  endtask

  initial begin : stimulus
    stim_row_t directed[27];
    int        random_start;
    bit        hold_issued;
    bit        paused;
    hold_issued = 1'b0;
    paused = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.end_of_input <= 1'b0;
    directed = '{
      row_err (8'h00, 0, 6'd0, ERR_BAD_TAG),        // bad tag, then drain
      row_none(8'hAA, 1),                           // drain ends at end of input
      row_none(8'hFF, 0),                           // new format, type 63
      row_hdr (8'h02, 0, 6'd63, 32'd2, 0, 0),
      row_pred(8'hFF, 0),
      row_pred(8'h00, 0),
      row_none(8'hC1, 0),
      row_err (8'hE0, 0, 6'd1, ERR_PARTIAL_LEN),
      row_none(8'h12, 1),
      row_none(8'hC5, 0),
      row_err (8'hFE, 1, 6'd5, ERR_PARTIAL_LEN),
      row_err (8'hC3, 1, 6'd3, ERR_TRUNC_HDR),      // tag alone at end of input
      row_none(8'hC4, 0),                           // five-byte length, all ones
      row_none(8'hFF, 0),
      row_none(8'hFF, 0),
      row_none(8'hFF, 0),
      row_none(8'hFF, 0),
      row_err (8'hFF, 1, 6'd4, ERR_TRUNC_BODY),     // body declared but input ends
      row_none(8'hC0, 0),                           // largest two-byte length
      row_none(8'hDF, 0),
      row_hdr (8'hFF, 0, 6'd0, 32'd8383, 0, 0),
      row_err (8'h5A, 1, 6'd0, ERR_TRUNC_BODY),     // body cut short
      row_hdr (8'hBF, 1, 6'd15, 32'd0, 1, 1),       // open length, empty
      row_err (8'h84, 1, 6'd1, ERR_TRUNC_HDR),
      row_hdr (8'h87, 0, 6'd1, 32'd0, 1, 0),        // open length body
      row_pred(8'h00, 0),
      row_pred(8'hFF, 1)
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      offered_bytes.push_back(directed[i]);
      send_byte(directed[i].data, directed[i].eoi, pick_gap());
    end

    random_start = live_bytes;
    while (live_bytes - random_start < RANDOM_BYTES) begin
      build_segment();
      foreach (segment[i]) begin
        offered_bytes.push_back(row_pred(segment[i].data, segment[i].eoi));
        send_byte(segment[i].data, segment[i].eoi, pick_gap());
      end
      if (!hold_issued && live_bytes - random_start > 150) begin
        // receiver goes quiet while bytes keep coming
        hold_issued = 1'b1;
        hold_req = 1'b1;
        no_gap_left = 80;
      end
      if (!paused && live_bytes - random_start > 350) begin
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        // let the monitor log the last transfer first
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("summary: %0d bytes taken, %0d headers, %0d body bytes, %0d errors checked",
             bytes_in, n_headers, n_bodies, n_errors);
    $display("summary: %0d bad results, %0d still pending", bad_results,
             pending_results.size());
    if (bad_results == 0 && pending_results.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  initial begin : receiver
    bit level;
    int run_left;
    int held;
    int r;
    level = 1'b0;
    run_left = 0;
    held = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        held++;
        if (held == HOLD_OFF_CYCLES) begin
          hold_req = 1'b0;
          held = 0;
        end
      end else begin
        if (run_left == 0) begin
          level = !level;
          r = $urandom_range(99);
          if (level)
            run_left = (r < 10) ? $urandom_range(50, 150) : $urandom_range(1, 12);
          else if (r < 85)
            run_left = $urandom_range(1, 3);
          else if (r < 95)
            run_left = $urandom_range(4, 12);
          else
            run_left = $urandom_range(20, 60);
        end
        out_ch.ready <= level;
        run_left--;
      end
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : monitor
    stim_row_t row;
    result_t   want;
    result_t   got;
    bit        has;
    string     diff;
    if (rst_n) begin
      // input side first so a same-cycle result would still find its entry
      if (in_ch.valid && in_ch.ready) begin
        row = offered_bytes.pop_front();
        bytes_in++;
        if (frame_phase != PH_DRAIN)
          live_bytes++;
        has = frame_byte(in_ch.data_byte, in_ch.end_of_input, want);
        if (row.typed) begin
          has = row.has_result;
          want = row.res;
        end
        if (has)
          pending_results.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.kind = out_ch.kind;
        got.packet_type = out_ch.packet_type;
        got.body_length = out_ch.body_length;
        got.length_open = out_ch.length_open;
        got.body_byte = out_ch.body_byte;
        got.last_in_packet = out_ch.last_in_packet;
        got.error_code = out_ch.error_code;
        if (pending_results.size() == 0) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS)
            $display("unexpected result transfer: %s", describe(got));
        end else begin
          want = pending_results.pop_front();
          diff = "";
          if (got.kind !== want.kind) diff = {diff, " kind"};
          if (got.packet_type !== want.packet_type) diff = {diff, " packet_type"};
          if (got.body_length !== want.body_length) diff = {diff, " body_length"};
          if (got.length_open !== want.length_open) diff = {diff, " length_open"};
          if (got.body_byte !== want.body_byte) diff = {diff, " body_byte"};
          if (got.last_in_packet !== want.last_in_packet) diff = {diff, " last_in_packet"};
          if (got.error_code !== want.error_code) diff = {diff, " error_code"};
          if (diff != "") begin
            bad_results++;
            if (bad_results <= MAX_REPORTS)
              $display("mismatch in%s\n  expected %s\n  actual   %s", diff,
                       describe(want), describe(got));
          end
          case (want.kind)
            KIND_HEADER: n_headers++;
            KIND_BODY:   n_bodies++;
            default:     n_errors++;
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles,
               pending_results.size());
      $display("tb: FAIL");
      $finish;
    end
  end

endmodule
